@@ rtl/led_matrix_chain_dirty_row_refresh_assert.svh @@
// Assertion macros used by the LED matrix refresh back end.
`ifndef LED_MATRIX_CHAIN_DIRTY_ROW_REFRESH_ASSERT_SVH
`define LED_MATRIX_CHAIN_DIRTY_ROW_REFRESH_ASSERT_SVH
`ifndef SYNTHESIS
// Check outside reset.
`define LMCDR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("lmcdr: assertion failed");
// Check on every edge, reset included.
`define LMCDR_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("lmcdr: assertion failed");
`else
`define LMCDR_ASSERT(lbl, prop)
`define LMCDR_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ rtl/lmcdr_pkg.sv @@
// Types, constants and helpers for the LED matrix refresh block.
`default_nettype none
package lmcdr_pkg;
	localparam int MAX_MODULES = 4;
	localparam int COL_MODULES = 4;
	localparam int CHAIN_CAP = (MAX_MODULES < COL_MODULES) ? MAX_MODULES : COL_MODULES;
	localparam int MOD_W = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
	localparam int IDX_W = MOD_W + 3;
	localparam int FRAME_DEPTH = MAX_MODULES * 8;
	localparam int CNT_W = $clog2(CHAIN_CAP + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// device registers
	localparam logic [3:0] REG_DECODE = 4'h9;
	localparam logic [3:0] REG_INTENSITY = 4'hA;
	localparam logic [3:0] REG_SCAN_LIMIT = 4'hB;
	localparam logic [3:0] REG_SHUTDOWN = 4'hC;
	localparam logic [3:0] REG_DISPLAY_TEST = 4'hF;
	localparam logic [7:0] DATA_SCAN_ALL = 8'h07;
	localparam logic [7:0] DATA_NORMAL_OP = 8'h01;

	localparam logic [2:0] PH_DECODE = 3'd0;
	localparam logic [2:0] PH_INTENSITY = 3'd1;
	localparam logic [2:0] PH_SCAN_LIMIT = 3'd2;
	localparam logic [2:0] PH_SHUTDOWN = 3'd3;
	localparam logic [2:0] PH_DISPLAY_TEST = 3'd4;

	// configuration register indexes
	localparam logic CFG_CHAIN_LENGTH = 1'b0;
	localparam logic CFG_STARTUP_INTENSITY = 1'b1;

	typedef enum logic [1:0] {
		ACT_PIXEL = 2'd0,
		ACT_FLUSH = 2'd1,
		ACT_INTENSITY = 2'd2,
		ACT_INIT = 2'd3
	} action_t;

	typedef struct packed {
		action_t kind;
		logic [4:0] column;
		logic [2:0] row;
		logic pixel_on;
		logic only_if_changed;
		logic [3:0] level;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] chain;
		logic [3:0] startup_intensity;
	} cfg_t;

	function automatic logic [CNT_W-1:0] chain_used(input logic [2:0] len);
		logic [CNT_W-1:0] n;
		if (len == 3'd0) begin
			n = CNT_W'(1);
		end else if (int'(len) > CHAIN_CAP) begin
			n = CNT_W'(CHAIN_CAP);
		end else begin
			n = CNT_W'(len);
		end
		return n;
	endfunction

	function automatic logic [3:0] init_addr(input logic [2:0] phase);
		logic [3:0] a;
		unique case (phase)
			PH_DECODE: a = REG_DECODE;
			PH_INTENSITY: a = REG_INTENSITY;
			PH_SCAN_LIMIT: a = REG_SCAN_LIMIT;
			PH_SHUTDOWN: a = REG_SHUTDOWN;
			default: a = REG_DISPLAY_TEST;
		endcase
		return a;
	endfunction

	function automatic logic [7:0] init_data(input logic [2:0] phase, input logic [3:0] startup);
		logic [7:0] d;
		unique case (phase)
			PH_INTENSITY: d = {4'b0, startup};
			PH_SCAN_LIMIT: d = DATA_SCAN_ALL;
			PH_SHUTDOWN: d = DATA_NORMAL_OP;
			default: d = 8'h00;
		endcase
		return d;
	endfunction
endpackage
`default_nettype wire

@@ rtl/lmcdr_front.sv @@
// Front end: config registers, request decode and filtering.
`default_nettype none
module lmcdr_front import lmcdr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [15:0] s_tdata,
	input wire logic [1:0] s_tuser,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [3:0] cfg_data,
	output cfg_t cfg,
	output logic push,
	output cmd_t push_cmd,
	input wire logic q_full
);
	logic [2:0] chain_len_q;
	logic [3:0] startup_q;
	logic init_done_q;
	logic accept;
	logic in_range;
	logic keep;

	assign cfg_ready = 1'b1;
	assign s_tready = !q_full;
	assign accept = s_tvalid && s_tready;

	assign cfg.chain = chain_used(chain_len_q);
	assign cfg.startup_intensity = startup_q;

	always_comb begin
		push_cmd.kind = action_t'(s_tuser);
		push_cmd.column = s_tdata[4:0];
		push_cmd.row = s_tdata[7:5];
		push_cmd.pixel_on = s_tdata[8];
		push_cmd.only_if_changed = s_tdata[9];
		push_cmd.level = s_tdata[13:10];
	end

	// a column whose module lies beyond the chain is dropped here
	assign in_range = int'(push_cmd.column[4:3]) < int'(cfg.chain);

	always_comb begin
		unique case (push_cmd.kind)
			ACT_PIXEL: keep = in_range;
			ACT_INIT: keep = !init_done_q;
			default: keep = 1'b1;
		endcase
	end

	assign push = accept && keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_len_q <= 3'd1;
			startup_q <= 4'd0;
			init_done_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_CHAIN_LENGTH: chain_len_q <= cfg_data[2:0];
					CFG_STARTUP_INTENSITY: startup_q <= cfg_data;
				endcase
			end
			if (accept && push_cmd.kind == ACT_INIT) begin
				init_done_q <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/lmcdr_queue.sv @@
// Short command queue between front end and sequencer.
`default_nettype none
module lmcdr_queue import lmcdr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire cmd_t push_cmd,
	output logic full,
	input wire logic pop,
	output cmd_t pop_cmd,
	output logic empty
);
	cmd_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] count_q;

	assign full = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign pop_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/lmcdr_back.sv @@
// Back end: frame store, dirty flags, word sequencer and output register.
`default_nettype none
`include "led_matrix_chain_dirty_row_refresh_assert.svh"
module lmcdr_back import lmcdr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire logic q_empty,
	input wire cmd_t q_cmd,
	output logic q_pop,
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [15:0] m_tdata,
	output logic m_tuser,
	output logic m_tlast
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_FLUSH = 3'b010,
		ST_BCAST = 3'b100
	} state_t;

	state_t state_q;
	logic [7:0] frame_q [FRAME_DEPTH];
	logic [7:0] dirty_q;
	logic [2:0] row_q;
	logic [CNT_W-1:0] mod_q;
	logic [2:0] phase_q;
	logic init_q;
	logic [3:0] level_q;
	logic out_v_q;
	logic [3:0] out_addr_q;
	logic [7:0] out_data_q;
	logic out_end_q;
	logic out_last_q;

	logic slot_free;
	logic load_out;
	logic [IDX_W-1:0] pix_idx;
	logic [IDX_W-1:0] fl_idx;
	logic [IDX_W-1:0] rd_idx;
	logic [7:0] rd_data;
	logic [7:0] mask;
	logic [7:0] new_byte;
	logic pix_write;
	logic row_dirty;
	logic higher_dirty;
	logic mod_one;
	logic [3:0] bc_addr;
	logic [7:0] bc_data;
	logic bc_last;

	assign slot_free = !out_v_q || m_tready;
	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign load_out = slot_free
		&& ((state_q == ST_FLUSH && row_dirty) || state_q == ST_BCAST);

	assign pix_idx = IDX_W'({q_cmd.column[4:3], q_cmd.row});
	assign fl_idx = IDX_W'({mod_q - CNT_W'(1), row_q});
	// one read port: pixel update in idle, row fetch while flushing
	assign rd_idx = (state_q == ST_IDLE) ? pix_idx : fl_idx;
	assign rd_data = frame_q[rd_idx];

	assign mask = 8'd1 << q_cmd.column[2:0];
	assign new_byte = q_cmd.pixel_on ? (rd_data | mask) : (rd_data & ~mask);
	assign pix_write = q_pop && q_cmd.kind == ACT_PIXEL
		&& !(q_cmd.only_if_changed && new_byte == rd_data);

	assign row_dirty = dirty_q[row_q];
	assign higher_dirty = |(dirty_q & 8'(8'hFE << row_q));
	assign mod_one = mod_q == CNT_W'(1);

	assign bc_addr = init_q ? init_addr(phase_q) : REG_INTENSITY;
	assign bc_data = init_q ? init_data(phase_q, cfg.startup_intensity) : {4'b0, level_q};
	assign bc_last = mod_one && (!init_q || phase_q == PH_DISPLAY_TEST);

	assign m_tvalid = out_v_q;
	assign m_tdata = {4'b0, out_data_q, out_addr_q};
	assign m_tuser = out_end_q;
	assign m_tlast = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < FRAME_DEPTH; i++) begin
				frame_q[i] <= 8'h00;
			end
			dirty_q <= 8'h00;
			row_q <= 3'd0;
			mod_q <= '0;
			phase_q <= PH_DECODE;
			init_q <= 1'b0;
			level_q <= 4'd0;
			out_v_q <= 1'b0;
			out_addr_q <= 4'd0;
			out_data_q <= 8'd0;
			out_end_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						unique case (q_cmd.kind)
							ACT_PIXEL: begin
								if (pix_write) begin
									frame_q[pix_idx] <= new_byte;
									dirty_q <= dirty_q | (8'd1 << q_cmd.row);
								end
							end
							ACT_FLUSH: begin
								row_q <= 3'd0;
								mod_q <= cfg.chain;
								state_q <= ST_FLUSH;
							end
							ACT_INTENSITY: begin
								init_q <= 1'b0;
								level_q <= q_cmd.level;
								mod_q <= cfg.chain;
								state_q <= ST_BCAST;
							end
							ACT_INIT: begin
								init_q <= 1'b1;
								phase_q <= PH_DECODE;
								mod_q <= cfg.chain;
								state_q <= ST_BCAST;
							end
						endcase
					end
				end
				ST_FLUSH: begin
					if (!row_dirty) begin
						// skip a clean row
						if (row_q == 3'd7) begin
							dirty_q <= 8'h00;
							state_q <= ST_IDLE;
						end else begin
							row_q <= row_q + 3'd1;
						end
					end else if (slot_free) begin
						out_addr_q <= {1'b0, row_q} + 4'd1;
						out_data_q <= rd_data;
						out_end_q <= mod_one;
						out_last_q <= mod_one && !higher_dirty;
						if (mod_one) begin
							if (!higher_dirty) begin
								dirty_q <= 8'h00;
								state_q <= ST_IDLE;
							end else begin
								row_q <= row_q + 3'd1;
								mod_q <= cfg.chain;
							end
						end else begin
							mod_q <= mod_q - CNT_W'(1);
						end
					end
				end
				ST_BCAST: begin
					if (slot_free) begin
						out_addr_q <= bc_addr;
						out_data_q <= bc_data;
						out_end_q <= mod_one;
						out_last_q <= bc_last;
						if (mod_one) begin
							if (bc_last) begin
								state_q <= ST_IDLE;
							end else begin
								phase_q <= phase_q + 3'd1;
								mod_q <= cfg.chain;
							end
						end else begin
							mod_q <= mod_q - CNT_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`LMCDR_ASSERT_ALWAYS(a_last_ends_transfer, (out_v_q && out_last_q) |-> out_end_q)
	`LMCDR_ASSERT(a_flush_clears_dirty, ($past(state_q) == ST_FLUSH && state_q == ST_IDLE) |-> dirty_q == 8'h00)
	`LMCDR_ASSERT(a_module_count_live, (state_q == ST_BCAST || state_q == ST_FLUSH) |-> mod_q != '0)
endmodule
`default_nettype wire

@@ rtl/led_matrix_chain_dirty_row_refresh.sv @@
// Top level of the dirty-row refresh block for chained 8x8 LED matrix modules.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tuser: action; s_tdata: column, row,
//          |           |                    |   pixel_on, only_if_changed, level
//  m_      | out       | m_tvalid/m_tready  | m_tdata: register_address, register_data;
//          |           |                    |   m_tuser: transfer_end; m_tlast: last
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// The front end takes one request per cycle while its four-entry queue has room.
// The sequencer pops a request while idle (a pixel write finishes there); a flush then
// emits one word per module for each dirty row and skips each clean row, a broadcast
// one word per module, and an init one word per module for each of its five registers.
// Reset clears the frame store, dirty flags, init flag and queue at once.
// A stalled output holds its word; the sequencer waits, the queue keeps filling.
`default_nettype none
module led_matrix_chain_dirty_row_refresh import lmcdr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// [4:0] column, [7:5] row, [8] pixel_on, [9] only_if_changed,
	// [13:10] level, [15:14] zero
	input wire logic [15:0] s_tdata,
	// [1:0] action
	input wire logic [1:0] s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// [3:0] register_address, [11:4] register_data, [15:12] zero
	output logic [15:0] m_tdata,
	// [0] transfer_end
	output logic m_tuser,
	output logic m_tlast,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [3:0] cfg_data
);
	cfg_t cfg;
	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic q_pop;
	cmd_t q_cmd;
	logic q_empty;

	lmcdr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg),
		.push(push),
		.push_cmd(push_cmd),
		.q_full(q_full)
	);

	lmcdr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(q_full),
		.pop(q_pop),
		.pop_cmd(q_cmd),
		.empty(q_empty)
	);

	lmcdr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.q_empty(q_empty),
		.q_cmd(q_cmd),
		.q_pop(q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);
endmodule
`default_nettype wire

@@ sim/refresh_word_checker.sv @@
// Predicts and checks the register words of the LED matrix refresh block.
`timescale 1ns / 100ps
module refresh_word_checker import lmcdr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [15:0] s_tdata,
	input logic [1:0] s_tuser,
	input logic m_tvalid,
	input logic m_tready,
	input logic [15:0] m_tdata,
	input logic m_tuser,
	input logic m_tlast,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic cfg_index,
	input logic [3:0] cfg_data,
	output int failures,
	output int outstanding
);
	typedef struct packed {
		logic [3:0] addr;
		logic [7:0] data;
		logic xfer_end;
		logic last;
	} led_word_t;

	led_word_t expected_words[$];
	logic [7:0] pixel_rows [FRAME_DEPTH];
	logic [7:0] dirty_flags;
	logic init_sent;
	logic [2:0] chain_setting;
	logic [3:0] startup_level;

	function automatic int modules_in_chain();
		int n;
		n = int'(chain_setting);
		if (n < 1) begin
			n = 1;
		end
		if (n > CHAIN_CAP) begin
			n = CHAIN_CAP;
		end
		return n;
	endfunction

	task automatic add_word(input logic [3:0] addr, input logic [7:0] data, input logic xfer_end);
		led_word_t w;
		w.addr = addr;
		w.data = data;
		w.xfer_end = xfer_end;
		w.last = 1'b0;
		expected_words.push_back(w);
	endtask

	// one word per module in use, chip select released on the final one
	task automatic broadcast(input logic [3:0] addr, input logic [7:0] data);
		int n;
		n = modules_in_chain();
		for (int m = 0; m < n; m++) begin
			add_word(addr, data, m + 1 == n);
		end
	endtask

	task automatic apply_request(input logic [1:0] kind, input logic [15:0] req);
		action_t act;
		logic [4:0] col;
		logic [2:0] row;
		logic on;
		logic only_changed;
		logic [3:0] lvl;
		logic [7:0] old_byte;
		logic [7:0] new_byte;
		int n;
		int idx;
		int first;
		act = action_t'(kind);
		col = req[4:0];
		row = req[7:5];
		on = req[8];
		only_changed = req[9];
		lvl = req[13:10];
		n = modules_in_chain();
		first = expected_words.size();
		case (act)
			ACT_PIXEL: begin
				// columns past the chain are dropped
				if (int'(col) < 8 * n) begin
					idx = int'(col >> 3) * 8 + int'(row);
					old_byte = pixel_rows[idx];
					new_byte = old_byte;
					new_byte[col[2:0]] = on;
					if (!(only_changed && new_byte == old_byte)) begin
						pixel_rows[idx] = new_byte;
						dirty_flags[row] = 1'b1;
					end
				end
			end
			ACT_FLUSH: begin
				for (int r = 0; r < 8; r++) begin
					if (dirty_flags[r]) begin
						// last module first, its byte is shifted furthest
						for (int m = n; m >= 1; m--) begin
							add_word(4'(r + 1), pixel_rows[(m - 1) * 8 + r], m == 1);
						end
					end
				end
				dirty_flags = '0;
			end
			ACT_INTENSITY: begin
				broadcast(REG_INTENSITY, {4'b0, lvl});
			end
			default: begin
				if (!init_sent) begin
					broadcast(REG_DECODE, 8'h00);
					broadcast(REG_INTENSITY, {4'b0, startup_level});
					broadcast(REG_SCAN_LIMIT, DATA_SCAN_ALL);
					broadcast(REG_SHUTDOWN, DATA_NORMAL_OP);
					broadcast(REG_DISPLAY_TEST, 8'h00);
					init_sent = 1'b1;
				end
			end
		endcase
		if (expected_words.size() > first) begin
			expected_words[expected_words.size() - 1].last = 1'b1;
		end
	endtask

	task automatic check_word();
		led_word_t got;
		led_word_t want;
		got.addr = m_tdata[3:0];
		got.data = m_tdata[11:4];
		got.xfer_end = m_tuser;
		got.last = m_tlast;
		if (expected_words.size() == 0) begin
			$error("word with nothing pending: register_address %0h register_data %0h",
				got.addr, got.data);
			failures++;
		end else begin
			want = expected_words.pop_front();
			if (got.addr !== want.addr) begin
				$error("register_address: expected %0h, got %0h", want.addr, got.addr);
				failures++;
			end
			if (got.data !== want.data) begin
				$error("register_data: expected %0h, got %0h", want.data, got.data);
				failures++;
			end
			if (got.xfer_end !== want.xfer_end) begin
				$error("transfer_end: expected %0b, got %0b", want.xfer_end, got.xfer_end);
				failures++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				failures++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_DEPTH; i++) begin
				pixel_rows[i] = 8'h00;
			end
			dirty_flags = '0;
			init_sent = 1'b0;
			chain_setting = 3'd1;
			startup_level = 4'd0;
			expected_words.delete();
			failures = 0;
		end else begin
			// words out at this edge belong to requests taken earlier
			if (m_tvalid && m_tready) begin
				check_word();
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_CHAIN_LENGTH) begin
					chain_setting = cfg_data[2:0];
				end else begin
					startup_level = cfg_data;
				end
			end
			if (s_tvalid && s_tready) begin
				apply_request(s_tuser, s_tdata);
			end
		end
		outstanding = expected_words.size();
	end
endmodule

@@ sim/tb.sv @@
// Stimulus, reset, clock and verdict for the LED matrix refresh block.
`timescale 1ns / 100ps
module tb import lmcdr_pkg::*; ();
	localparam int LIMIT = 1000000;
	localparam int IDLE_TAIL = 64;
	localparam int PHASES = 8;
	localparam int PHASE_REQUESTS = 36;
	// request layout: [1:0] action for tuser, [17:2] the tdata word
	localparam int REQ_W = 18;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = CFG_CHAIN_LENGTH;
	logic [3:0] cfg_data = '0;

	int failures;
	int outstanding;
	int cycle_count = 0;
	int span = 8;
	bit steady = 1'b0;
	int chain_plan [PHASES] = '{1, 3, 2, 4, 0, 7, 12, 4};

	led_matrix_chain_dirty_row_refresh DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	refresh_word_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.failures(failures),
		.outstanding(outstanding)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver: long ready stretches broken by short stalls
	initial begin
		@(posedge arst_n);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!steady) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
	end

	function automatic logic [REQ_W-1:0] pack_request(input action_t act, input logic [4:0] col,
			input logic [2:0] row, input logic on, input logic only_changed,
			input logic [3:0] lvl);
		return {2'b00, lvl, only_changed, on, row, col, act};
	endfunction

	function automatic logic [REQ_W-1:0] random_request();
		logic [REQ_W-1:0] req;
		int pick;
		req = REQ_W'($urandom);
		req[REQ_W-1:REQ_W-2] = 2'b00;
		pick = $urandom_range(0, 99);
		if (pick < 72) begin
			req[1:0] = ACT_PIXEL;
			// mostly columns inside the chain, now and then anywhere
			if ($urandom_range(0, 9) != 0) begin
				req[6:2] = 5'($urandom_range(0, span - 1));
			end
		end else if (pick < 90) begin
			req[1:0] = ACT_FLUSH;
		end else if (pick < 97) begin
			req[1:0] = ACT_INTENSITY;
		end else begin
			req[1:0] = ACT_INIT;
		end
		return req;
	endfunction

	task automatic issue(input logic [REQ_W-1:0] req);
		if (!steady && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tuser <= req[1:0];
		s_tdata <= req[REQ_W-1:2];
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// hold until every word is out, then let queued pixel writes retire
	task automatic settle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	task automatic write_settings(input logic [3:0] chain_val, input logic [3:0] startup_val);
		int n;
		n = int'(chain_val[2:0]);
		if (n < 1) begin
			n = 1;
		end
		if (n > CHAIN_CAP) begin
			n = CHAIN_CAP;
		end
		span = 8 * n;
		cfg_index <= CFG_CHAIN_LENGTH;
		cfg_data <= chain_val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= CFG_STARTUP_INTENSITY;
		cfg_data <= startup_val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// chain length zero runs as a single module
		write_settings(4'd0, 4'd15);
		issue(pack_request(ACT_FLUSH, 5'd0, 3'd0, 1'b0, 1'b0, 4'd0));
		issue(pack_request(ACT_PIXEL, 5'd0, 3'd0, 1'b1, 1'b0, 4'd0));
		issue(pack_request(ACT_PIXEL, 5'd7, 3'd7, 1'b1, 1'b1, 4'd15));
		issue(pack_request(ACT_PIXEL, 5'd31, 3'd3, 1'b1, 1'b0, 4'd0));
		issue(pack_request(ACT_PIXEL, 5'd8, 3'd5, 1'b1, 1'b0, 4'd0));
		issue(pack_request(ACT_PIXEL, 5'd0, 3'd0, 1'b1, 1'b1, 4'd0));
		issue(pack_request(ACT_FLUSH, 5'd31, 3'd7, 1'b1, 1'b1, 4'd15));
		issue(pack_request(ACT_PIXEL, 5'd0, 3'd0, 1'b1, 1'b1, 4'd0));
		issue(pack_request(ACT_PIXEL, 5'd7, 3'd7, 1'b0, 1'b0, 4'd0));
		issue(pack_request(ACT_FLUSH, 5'd0, 3'd0, 1'b0, 1'b0, 4'd0));
		issue(pack_request(ACT_INTENSITY, 5'd0, 3'd0, 1'b0, 1'b0, 4'd0));
		issue(pack_request(ACT_INTENSITY, 5'd0, 3'd0, 1'b0, 1'b0, 4'd15));
		issue(pack_request(ACT_INIT, 5'd0, 3'd0, 1'b0, 1'b0, 4'd0));
		issue(pack_request(ACT_INIT, 5'd0, 3'd0, 1'b0, 1'b0, 4'd0));
		settle();

		write_settings(4'd4, 4'd0);
		issue(pack_request(ACT_PIXEL, 5'd31, 3'd0, 1'b1, 1'b0, 4'd0));
		issue(pack_request(ACT_PIXEL, 5'd24, 3'd7, 1'b1, 1'b1, 4'd0));
		issue(pack_request(ACT_PIXEL, 5'd16, 3'd3, 1'b1, 1'b0, 4'd0));
		issue(pack_request(ACT_PIXEL, 5'd8, 3'd3, 1'b1, 1'b0, 4'd0));
		issue(pack_request(ACT_PIXEL, 5'd0, 3'd3, 1'b0, 1'b1, 4'd0));
		issue(pack_request(ACT_FLUSH, 5'd0, 3'd0, 1'b0, 1'b0, 4'd0));
		issue(pack_request(ACT_INTENSITY, 5'd0, 3'd0, 1'b0, 1'b0, 4'd9));
		issue(pack_request(ACT_FLUSH, 5'd0, 3'd0, 1'b0, 1'b0, 4'd0));
		settle();

		// above the cap clamps to the full chain; bytes kept from before
		write_settings(4'd7, 4'd5);
		issue(pack_request(ACT_PIXEL, 5'd31, 3'd7, 1'b0, 1'b0, 4'd0));
		issue(pack_request(ACT_FLUSH, 5'd0, 3'd0, 1'b0, 1'b0, 4'd0));

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph == PHASES - 1) begin
				steady = 1'b1;
			end
			write_settings(4'(chain_plan[ph]), 4'($urandom));
			for (int i = 0; i < PHASE_REQUESTS; i++) begin
				if (ph == 2 && i == 20) begin
					settle();
				end
				issue(random_request());
			end
		end
		settle();

		if (failures == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
